/* hw/rtl/slfd_pkg.sv */
// ----------------------------------------------------------------------------
// slfd_pkg
// Shared types, codes and constants of the sync/length frame deframer.
// ----------------------------------------------------------------------------
package slfd_pkg;

  localparam int unsigned BufferBytesDef = 256;
  localparam int unsigned QueueDepthDef  = 4;

  localparam logic [7:0]  Sync1    = 8'hAB;
  localparam logic [7:0]  Sync2    = 8'hCD;
  localparam logic [7:0]  Foot1    = 8'hDC;
  localparam logic [7:0]  Foot2    = 8'hBA;
  localparam logic [15:0] IdObfOff = 16'h0514;
  localparam logic [15:0] IdObfOn  = 16'h6902;

  localparam logic [7:0] MaskTable [16] = '{
    8'h16, 8'h6C, 8'h14, 8'hE6, 8'h2E, 8'h91, 8'h0D, 8'h40,
    8'h21, 8'h35, 8'hD5, 8'h40, 8'h13, 8'h03, 8'hE9, 8'h80
  };

  typedef enum logic [2:0] {
    PhHunt  = 3'd0,
    PhSync2 = 3'd1,
    PhSzLo  = 3'd2,
    PhSzHi  = 3'd3,
    PhBody  = 3'd4,
    PhFt1   = 3'd5,
    PhFt2   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KindBody      = 2'd0,
    KindOk        = 2'd1,
    KindBadFooter = 2'd2,
    KindTooLarge  = 2'd3
  } kind_e;

  // One queue entry carries one or two results. A pair holds the held first
  // body byte (index zero) in raw0 and the second byte in raw1.
  typedef struct packed {
    kind_e       kind;
    logic        pair;
    logic [7:0]  raw0;
    logic [7:0]  raw1;
    logic [7:0]  idx;
    logic        last;
    logic [15:0] size;
    logic        obf;
  } entry_t;

endpackage

/* hw/rtl/slfd_parser.sv */
// ----------------------------------------------------------------------------
// slfd_parser
// Front part: hunts for sync, reads the size, tracks the body and footer,
// and pushes classified result entries into the queue.
// ----------------------------------------------------------------------------
module slfd_parser import slfd_pkg::*; #(
  parameter int unsigned BufferBytes = BufferBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       full_i,
  output logic       push_o,
  output entry_t     entry_o
);

  localparam int unsigned CntW = $clog2(BufferBytes);

  phase_e      phase_q, phase_d;
  logic [15:0] size_q, size_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]  held_q, held_d;
  logic        obf_on_q, obf_on_d;
  logic        frame_obf_q, frame_obf_d;

  logic        accept;
  logic [15:0] size_new;
  logic        too_large;
  logic        body_last;
  logic [15:0] frame_id;
  logic        id_obf;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign size_new   = {rx_byte_i, size_q[7:0]};
  assign too_large  = ({1'b0, size_new} + 17'd8) > 17'(BufferBytes);
  assign body_last  = (17'(cnt_q) + 17'd1) >= ({1'b0, size_q} + 17'd2);
  assign frame_id   = {rx_byte_i, held_q};

  always_comb begin
    id_obf = obf_on_q;
    if (frame_id == IdObfOff) begin
      id_obf = 1'b0;
    end
    if (frame_id == IdObfOn) begin
      id_obf = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      size_q      <= '0;
      cnt_q       <= '0;
      held_q      <= '0;
      obf_on_q    <= 1'b1;
      frame_obf_q <= 1'b1;
    end else begin
      phase_q     <= phase_d;
      size_q      <= size_d;
      cnt_q       <= cnt_d;
      held_q      <= held_d;
      obf_on_q    <= obf_on_d;
      frame_obf_q <= frame_obf_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    size_d      = size_q;
    cnt_d       = cnt_q;
    held_d      = held_q;
    obf_on_d    = obf_on_q;
    frame_obf_d = frame_obf_q;
    push_o      = 1'b0;
    entry_o     = '{kind: KindBody, pair: 1'b0, raw0: 8'd0, raw1: 8'd0, idx: 8'd0,
                    last: 1'b0, size: size_q, obf: frame_obf_q};
    if (accept) begin
      unique case (phase_q)
        PhSync2: begin
          if (rx_byte_i == Sync2) begin
            phase_d = PhSzLo;
          end else if (rx_byte_i != Sync1) begin
            phase_d = PhHunt;
          end
        end
        PhSzLo: begin
          size_d  = {8'd0, rx_byte_i};
          phase_d = PhSzHi;
        end
        PhSzHi: begin
          size_d = size_new;
          if (too_large) begin
            push_o        = 1'b1;
            entry_o.kind  = KindTooLarge;
            entry_o.size  = size_new;
            phase_d       = PhHunt;
          end else begin
            cnt_d   = '0;
            phase_d = PhBody;
          end
        end
        PhBody: begin
          if (cnt_q == '0) begin
            held_d = rx_byte_i;
          end else begin
            push_o       = 1'b1;
            entry_o.raw1 = rx_byte_i;
            entry_o.idx  = 8'(cnt_q);
            entry_o.last = body_last;
            if (cnt_q == CntW'(1)) begin
              frame_obf_d  = id_obf;
              entry_o.pair = 1'b1;
              entry_o.raw0 = held_q;
              entry_o.obf  = id_obf;
            end
          end
          cnt_d = cnt_q + CntW'(1);
          if (body_last) begin
            phase_d = PhFt1;
          end
        end
        PhFt1: begin
          held_d  = rx_byte_i;
          phase_d = PhFt2;
        end
        PhFt2: begin
          push_o = 1'b1;
          if (held_q == Foot1 && rx_byte_i == Foot2) begin
            obf_on_d     = frame_obf_q;
            entry_o.kind = KindOk;
          end else begin
            entry_o.kind = KindBadFooter;
          end
          phase_d = PhHunt;
        end
        default: begin
          phase_d = (rx_byte_i == Sync1) ? PhSync2 : PhHunt;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/slfd_queue.sv */
// ----------------------------------------------------------------------------
// slfd_queue
// Short register queue of result entries between the parser and the emitter.
// ----------------------------------------------------------------------------
module slfd_queue import slfd_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   nonempty_o,
  output entry_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

/* hw/rtl/slfd_emitter.sv */
// ----------------------------------------------------------------------------
// slfd_emitter
// Back part: splits pair entries, removes the obfuscation mask and holds
// each result item in the output register until it is taken.
// ----------------------------------------------------------------------------
module slfd_emitter import slfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        nonempty_i,
  input  entry_t      head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  body_byte_o,
  output logic [7:0]  body_index_o,
  output logic        body_last_o,
  output logic [15:0] body_size_o
);

  logic        valid_q;
  logic        half_q;
  logic        load;
  logic        first_half;
  logic [7:0]  raw;
  logic [7:0]  idx;
  logic [7:0]  data;
  kind_e       kind_q;
  logic [7:0]  byte_q;
  logic [7:0]  idx_q;
  logic        last_q;
  logic [15:0] size_q;

  assign load       = nonempty_i && (!valid_q || out_ready_i);
  assign first_half = head_i.pair && !half_q;
  assign pop_o      = load && !first_half;
  assign raw        = first_half ? head_i.raw0 : head_i.raw1;
  assign idx        = first_half ? 8'd0 : head_i.idx;

  always_comb begin
    data = raw;
    if (head_i.obf) begin
      data = raw ^ MaskTable[idx[3:0]];
    end
    if (head_i.kind != KindBody) begin
      data = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        half_q  <= first_half;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= head_i.kind;
      byte_q <= data;
      idx_q  <= idx;
      last_q <= first_half ? 1'b0 : head_i.last;
      size_q <= head_i.size;
    end
  end

  assign out_valid_o  = valid_q;
  assign kind_o       = kind_q;
  assign body_byte_o  = byte_q;
  assign body_index_o = idx_q;
  assign body_last_o  = last_q;
  assign body_size_o  = size_q;

endmodule

/* hw/rtl/sync_length_frame_deframer.sv */
// ----------------------------------------------------------------------------
// sync_length_frame_deframer
// Pulls framed messages (sync AB CD, little-endian size, body, footer DC BA)
// out of a received byte stream and removes the body obfuscation mask.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+----------------------------
//   in       | input     | in_valid_i/in_ready_o | rx_byte_i
//   out      | output    | out_valid_o/out_ready_i | kind_o, body_byte_o,
//            |           |                       | body_index_o, body_last_o,
//            |           |                       | body_size_o
//
// One received byte is accepted per cycle while the queue is not full.
// A queued result enters the output register when it is empty or taken;
// the second body byte of a frame yields two results, sent one by one.
// The queue holds QueueDepth entries; in_ready_o drops only when it is full.
// Reset puts the parser into the hunt with obfuscation on and empties queue
// and output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer import slfd_pkg::*; #(
  parameter int unsigned BufferBytes = BufferBytesDef,
  parameter int unsigned QueueDepth  = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  body_byte_o,
  output logic [7:0]  body_index_o,
  output logic        body_last_o,
  output logic [15:0] body_size_o
);

  logic   full;
  logic   push;
  logic   pop;
  logic   nonempty;
  entry_t entry;
  entry_t head;

  slfd_parser #(
    .BufferBytes(BufferBytes)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .rx_byte_i (rx_byte_i),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (entry)
  );

  slfd_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .entry_i   (entry),
    .full_o    (full),
    .pop_i     (pop),
    .nonempty_o(nonempty),
    .head_o    (head)
  );

  slfd_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonempty_i  (nonempty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .body_byte_o (body_byte_o),
    .body_index_o(body_index_o),
    .body_last_o (body_last_o),
    .body_size_o (body_size_o)
  );

  a_status_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KindBody) |->
      (body_byte_o == 8'd0 && body_index_o == 8'd0 && !body_last_o))
    else $error("status item carries body fields");

  a_full_implies_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("queue full while output register is empty");

  a_too_large_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindTooLarge) |->
      (({1'b0, body_size_o} + 17'd8) > 17'(BufferBytes)))
    else $error("size rejected although it fits");

endmodule
